// ===== sv/planar_tile_decoder_top_defines.svh =====
// Assertion macros used by the checker file of the tile decoder.
// Every macro samples on clk_i and is quiet while rst_ni is low.
`ifndef PLANAR_TILE_DECODER_TOP_DEFINES_SVH
`define PLANAR_TILE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication
`define PTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ptd_pkg.sv =====
package ptd_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PIXEL   = 2'd0,
    ST_REJECT  = 2'd1,
    ST_UNAVAIL = 2'd2,
    ST_TRUNC   = 2'd3
  } status_e;

  // Pixel format codes
  localparam logic [1:0] FMT_2BPP = 2'd0;
  localparam logic [1:0] FMT_4BPP = 2'd1;
  localparam logic [1:0] FMT_8BPP = 2'd2;
  localparam logic [1:0] FMT_BAD  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_PIXEL_FORMAT   = 3'd0;
  localparam logic [2:0] REG_TILE_TOTAL     = 3'd1;
  localparam logic [2:0] REG_SOURCE_ADDRESS = 3'd2;
  localparam logic [2:0] REG_IN_VIDEO_RAM   = 3'd3;
  localparam logic [2:0] REG_PALETTE_START  = 3'd4;

  // Conflict mask bits
  localparam logic [2:0] MASK_BAD_DEF  = 3'b001;
  localparam logic [2:0] MASK_MISALIGN = 3'b010;
  localparam logic [2:0] MASK_BEYOND   = 3'b100;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       first_of_asset;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  conflict_mask;
    logic [11:0] tile_number;
    logic [5:0]  pixel_position;
    logic [7:0]  color_index;
    logic        last_of_tile;
    logic        last_of_asset;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  pixel_format;
    logic [12:0] tile_total;
    logic [31:0] source_address;
    logic        in_video_ram;
    logic [7:0]  palette_start;
  } cfg_t;

  // Command from front to back: a finished tile or a single error result
  typedef struct packed {
    logic        is_pixel;
    status_e     status;
    logic [2:0]  mask;
    logic [11:0] tile;
    logic        last;
    logic        bank;
    logic [1:0]  fmt;
  } cmd_t;

  // Byte write into the tile memory
  typedef struct packed {
    logic       en;
    logic       bank;
    logic [2:0] row;
    logic [2:0] lane;
    logic [7:0] data;
  } wr_t;

endpackage

// ===== sv/ptd_fifo.sv =====
module ptd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ptd_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          head_valid_o,
  output ptd_pkg::cmd_t head_o
);
  import ptd_pkg::*;

  cmd_t       entry_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = entry_q[rp_q];

  // Advance pointers and count
  always_comb begin
    wp_d  = push_i ? ~wp_q : wp_q;
    rp_d  = pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wp_q] <= cmd_i;
    end
  end

endmodule

// ===== sv/ptd_front.sv =====
module ptd_front #(
  parameter int MAX_TILE_BYTES = 64,
  parameter int MAX_TILES      = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ptd_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  input  ptd_pkg::in_item_t in_item_i,
  output logic             in_stall_o,
  input  logic             q_full_i,
  output logic             push_o,
  output ptd_pkg::cmd_t    cmd_o,
  output ptd_pkg::wr_t     wr_o
);
  import ptd_pkg::*;

  localparam logic [1:0]  PH_IDLE    = 2'd0;
  localparam logic [1:0]  PH_ACTIVE  = 2'd1;
  localparam logic [1:0]  PH_STOPPED = 2'd2;
  localparam logic [16:0] MaxTiles   = 17'(MAX_TILES);
  localparam logic [6:0]  MaxBytes   = 7'(MAX_TILE_BYTES);

  logic [1:0]  phase_q, phase_d;
  logic [5:0]  bc_q, bc_d;
  logic [12:0] tc_q, tc_d;
  logic        bank_q, bank_d;

  logic        accept;
  logic [6:0]  bpt;
  logic [18:0] span;
  logic        bad_def, misalign, beyond, pal_over;
  logic [2:0]  mask;
  logic        active;
  logic [5:0]  bc_cur, bc_inc;
  logic [12:0] tc_cur;
  logic        last_tile;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Tile size and span of the asset
  always_comb begin
    case (cfg_i.pixel_format)
      FMT_2BPP: begin
        bpt  = 7'd16;
        span = {2'b00, cfg_i.tile_total, 4'b0000};
      end
      FMT_4BPP: begin
        bpt  = 7'd32;
        span = {1'b0, cfg_i.tile_total, 5'b00000};
      end
      FMT_8BPP: begin
        bpt  = 7'd64;
        span = {cfg_i.tile_total, 6'b000000};
      end
      default: begin
        bpt  = 7'd0;
        span = '0;
      end
    endcase
  end

  // Check the configuration
  always_comb begin
    bad_def = (cfg_i.tile_total == 13'd0) || ({4'b0000, cfg_i.tile_total} > MaxTiles) ||
              (cfg_i.pixel_format == FMT_BAD);
    case (cfg_i.pixel_format)
      FMT_2BPP: begin
        misalign = (cfg_i.source_address[3:0] != 4'd0);
        pal_over = (cfg_i.palette_start > 8'd252);
      end
      FMT_4BPP: begin
        misalign = (cfg_i.source_address[4:0] != 5'd0);
        pal_over = (cfg_i.palette_start > 8'd240);
      end
      default: begin
        misalign = (cfg_i.source_address[5:0] != 6'd0);
        pal_over = (cfg_i.palette_start != 8'd0);
      end
    endcase
    beyond = cfg_i.in_video_ram &&
             ((cfg_i.source_address > 32'd65536) ||
              (({1'b0, span} + {3'b000, cfg_i.source_address[16:0]}) > 20'd65536));
    if (bad_def) begin
      mask = MASK_BAD_DEF;
    end else begin
      mask = (misalign ? MASK_MISALIGN : 3'b000) | (beyond ? MASK_BEYOND : 3'b000) |
             (pal_over ? MASK_BAD_DEF : 3'b000);
    end
  end

  // Classify the item, buffer its byte, hand finished work to the back
  always_comb begin
    phase_d   = phase_q;
    bc_d      = bc_q;
    tc_d      = tc_q;
    bank_d    = bank_q;
    push_o    = 1'b0;
    cmd_o     = '0;
    wr_o      = '0;
    active    = (phase_q == PH_ACTIVE);
    bc_cur    = bc_q;
    tc_cur    = tc_q;
    bc_inc    = bc_q + 6'd1;
    last_tile = 1'b0;
    if (accept) begin
      if (in_item_i.first_of_asset) begin
        bc_cur = '0;
        tc_cur = '0;
        bc_d   = '0;
        tc_d   = '0;
        if (mask != 3'b000) begin
          phase_d       = PH_STOPPED;
          active        = 1'b0;
          push_o        = 1'b1;
          cmd_o.is_pixel = 1'b0;
          cmd_o.status  = ST_REJECT;
          cmd_o.mask    = mask;
        end else begin
          phase_d = PH_ACTIVE;
          active  = 1'b1;
        end
      end
      bc_inc    = bc_cur + 6'd1;
      last_tile = ({1'b0, tc_cur} + 14'd1) >= {1'b0, cfg_i.tile_total};
      if (active) begin
        if (!in_item_i.byte_present) begin
          phase_d       = PH_STOPPED;
          push_o        = 1'b1;
          cmd_o.is_pixel = 1'b0;
          cmd_o.status  = ((tc_cur == 13'd0) && (bc_cur == 6'd0)) ? ST_UNAVAIL : ST_TRUNC;
          cmd_o.tile    = tc_cur[11:0];
        end else if ((bpt == 7'd0) || (bpt > MaxBytes)) begin
          // drop the asset silently on an unusable format
          phase_d = PH_STOPPED;
        end else begin
          wr_o.en   = 1'b1;
          wr_o.bank = bank_q;
          wr_o.row  = bc_cur[3:1];
          wr_o.lane = {bc_cur[5:4], bc_cur[0]};
          wr_o.data = in_item_i.data_byte;
          if (bc_inc == bpt[5:0]) begin
            bc_d           = '0;
            tc_d           = tc_cur + 13'd1;
            bank_d         = ~bank_q;
            push_o         = 1'b1;
            cmd_o.is_pixel = 1'b1;
            cmd_o.status   = ST_PIXEL;
            cmd_o.tile     = tc_cur[11:0];
            cmd_o.last     = last_tile;
            cmd_o.bank     = bank_q;
            cmd_o.fmt      = cfg_i.pixel_format;
            if (last_tile) begin
              phase_d = PH_STOPPED;
            end
          end else begin
            bc_d = bc_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bc_q    <= '0;
      tc_q    <= '0;
      bank_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      tc_q    <= tc_d;
      bank_q  <= bank_d;
    end
  end

endmodule

// ===== sv/ptd_back.sv =====
module ptd_back #(
  parameter int MAX_TILE_BYTES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptd_pkg::wr_t       wr_i,
  input  logic               head_valid_i,
  input  ptd_pkg::cmd_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ptd_pkg::out_item_t out_item_o
);
  import ptd_pkg::*;

  // One byte lane per bitplane that a tile of the largest size carries
  localparam int Lanes = MAX_TILE_BYTES / 8;
  localparam int LaneW = $clog2(Lanes);

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_PREP = 2'd1;
  localparam logic [1:0] BK_RUN  = 2'd2;

  // Two banks of eight rows; a row holds one byte of each bitplane
  logic [7:0] mem_q [16][Lanes];
  logic [7:0] row_q [Lanes];

  logic [1:0] state_q, state_d;
  logic [5:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;
  logic       can_load;
  logic [3:0] planes;
  logic [7:0] color;

  assign can_load    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Write bytes from the front
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[{wr_i.bank, wr_i.row}][wr_i.lane[LaneW-1:0]] <= wr_i.data;
    end
  end

  // Read the row of the next pixel
  always_ff @(posedge clk_i) begin
    row_q <= mem_q[{head_i.bank, pos_d[5:3]}];
  end

  // Gather the planes of the current pixel, leftmost from bit 7
  always_comb begin
    case (head_i.fmt)
      FMT_2BPP: planes = 4'd2;
      FMT_4BPP: planes = 4'd4;
      default:  planes = 4'd8;
    endcase
    color = '0;
    for (int p = 0; p < Lanes; p++) begin
      if (p < int'(planes)) begin
        color[p] = row_q[p][~pos_q[2:0]];
      end
    end
  end

  // Sequence one command into results
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    pop_o   = 1'b0;
    out_d   = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      BK_IDLE: begin
        if (head_valid_i) begin
          if (!head_i.is_pixel) begin
            if (can_load) begin
              pop_o                = 1'b1;
              out_valid_d          = 1'b1;
              out_d.status         = head_i.status;
              out_d.conflict_mask  = head_i.mask;
              out_d.tile_number    = head_i.tile;
              out_d.pixel_position = '0;
              out_d.color_index    = '0;
              out_d.last_of_tile   = 1'b1;
              out_d.last_of_asset  = 1'b1;
            end
          end else begin
            state_d = BK_PREP;
            pos_d   = '0;
          end
        end
      end
      BK_PREP: begin
        state_d = BK_RUN;
      end
      BK_RUN: begin
        if (can_load) begin
          out_valid_d          = 1'b1;
          out_d.status         = ST_PIXEL;
          out_d.conflict_mask  = '0;
          out_d.tile_number    = head_i.tile;
          out_d.pixel_position = pos_q;
          out_d.color_index    = color;
          out_d.last_of_tile   = (pos_q == 6'd63);
          out_d.last_of_asset  = (pos_q == 6'd63) && head_i.last;
          if (pos_q == 6'd63) begin
            pop_o   = 1'b1;
            state_d = BK_IDLE;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 6'd1;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result while stalled
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ===== sv/planar_tile_decoder_top.sv =====
// Planar tile decoder: takes one source byte per item and gives 64 palette
// indices per 8x8 tile of 2, 4 or 8 bitplanes, or one error result. The front
// checks the configuration on a first byte and writes bytes, one per cycle
// while the queue is not full, into one of two tile banks; the back reads the
// other bank one row per eight pixels and gives one pixel per cycle while the
// output is not stalled, after a preparation state at the start of each tile
// for the first row read. A two-entry queue between front and back holds at
// most two finished tiles; while it is full, input is stalled. MAX_TILE_BYTES
// (16, 32 or 64) sizes the tile memory; MAX_TILES bounds tile_total. The user
// is bound to write configuration through the APB-style port only while the
// block is idle; the block itself does not enforce this.
module planar_tile_decoder_top #(
  parameter int MAX_TILE_BYTES = 64,
  parameter int MAX_TILES      = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ptd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ptd_pkg::out_item_t out_item_o
);
  import ptd_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [2:0] reg_idx;
  logic       q_full;
  logic       push;
  cmd_t       cmd;
  wr_t        wr;
  logic       pop;
  logic       head_valid;
  cmd_t       head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format   <= FMT_2BPP;
      cfg_q.tile_total     <= 13'd1;
      cfg_q.source_address <= '0;
      cfg_q.in_video_ram   <= 1'b1;
      cfg_q.palette_start  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PIXEL_FORMAT:   cfg_q.pixel_format   <= pwdata[1:0];
        REG_TILE_TOTAL:     cfg_q.tile_total     <= pwdata[12:0];
        REG_SOURCE_ADDRESS: cfg_q.source_address <= pwdata;
        REG_IN_VIDEO_RAM:   cfg_q.in_video_ram   <= pwdata[0];
        REG_PALETTE_START:  cfg_q.palette_start  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back configuration
  always_comb begin
    unique case (reg_idx)
      REG_PIXEL_FORMAT:   prdata = {30'd0, cfg_q.pixel_format};
      REG_TILE_TOTAL:     prdata = {19'd0, cfg_q.tile_total};
      REG_SOURCE_ADDRESS: prdata = cfg_q.source_address;
      REG_IN_VIDEO_RAM:   prdata = {31'd0, cfg_q.in_video_ram};
      REG_PALETTE_START:  prdata = {24'd0, cfg_q.palette_start};
      default:            prdata = '0;
    endcase
  end

  ptd_front #(
    .MAX_TILE_BYTES (MAX_TILE_BYTES),
    .MAX_TILES      (MAX_TILES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (cmd),
    .wr_o       (wr)
  );

  ptd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  ptd_back #(
    .MAX_TILE_BYTES (MAX_TILE_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

// ===== sv/ptd_checker.sv =====
`include "planar_tile_decoder_top_defines.svh"

module ptd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ptd_pkg::out_item_t out_item_o
);
  import ptd_pkg::*;

  logic        out_take;
  logic        run_open;
  logic        run_next;
  logic        is_error;
  logic        error_final;
  logic [5:0]  next_pos_q;
  logic [11:0] tile_q;

  assign out_take    = out_valid_o && !out_stall_i;
  assign run_open    = out_take && (out_item_o.status == ST_PIXEL) &&
                       !out_item_o.last_of_tile;
  assign run_next    = out_valid_o && (out_item_o.status == ST_PIXEL) &&
                       (out_item_o.pixel_position == next_pos_q) &&
                       (out_item_o.tile_number == tile_q);
  assign is_error    = out_valid_o && (out_item_o.status != ST_PIXEL);
  assign error_final = out_item_o.last_of_tile && out_item_o.last_of_asset &&
                       (out_item_o.pixel_position == 6'd0) &&
                       (out_item_o.color_index == 8'd0);

  // Track the position and tile that the next pixel of a run must carry
  always_ff @(posedge clk_i) begin
    next_pos_q <= out_item_o.pixel_position + 6'd1;
    tile_q     <= out_item_o.tile_number;
  end

  // A stalled result stays and holds its payload
  `PTD_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "stalled result changed")

  // Pixels of one tile leave back to back and in order
  `PTD_ASSERT_NXT(a_pixel_run, run_open, run_next, "pixel run broken")

  // Only a rejection carries a conflict mask
  `PTD_ASSERT_IMP(a_mask_only_reject, out_valid_o, (out_item_o.status == ST_REJECT) == (out_item_o.conflict_mask != 3'b000), "conflict mask on wrong status")

  // An error result closes both tile and asset and carries no pixel
  `PTD_ASSERT_IMP(a_error_closes, is_error, error_final, "error result not final")

endmodule

bind planar_tile_decoder_top ptd_checker u_ptd_checker (.*);
